### src/cpd_pkg.sv
// ============================================================================
// Command packet deframer package
// Shared types, event codes and sizing constants for the deframer blocks.
// ============================================================================
package cpd_pkg;

    localparam int PARAM_DEPTH_DEF = 32;
    localparam int MAX_RUN         = 31;

    localparam logic [1:0] KIND_BYTE  = 2'd0;
    localparam logic [1:0] KIND_END   = 2'd1;
    localparam logic [1:0] KIND_RAISE = 2'd2;

    localparam logic [2:0] EV_PARAM      = 3'd0;
    localparam logic [2:0] EV_OVERFLOW   = 3'd1;
    localparam logic [2:0] EV_BAD_CHECK  = 3'd2;
    localparam logic [2:0] EV_INCOMPLETE = 3'd3;
    localparam logic [2:0] EV_RAISED     = 3'd4;

    localparam logic REG_READY_ENABLE = 1'b0;
    localparam logic REG_READY_CODE   = 1'b1;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] byte_value;
    } t_cpd_in;

    typedef struct packed {
        logic [2:0] event_res;
        logic [7:0] command;
        logic [4:0] param_count;
        logic [4:0] param_index;
        logic [7:0] param_byte;
        logic       last;
        logic [7:0] good_check;
        logic       ready_line;
    } t_cpd_out;

    typedef struct packed {
        logic       is_run;
        logic [2:0] event_res;
        logic [7:0] command;
        logic [4:0] param_count;
        logic [4:0] run_len;
        logic [7:0] good_check;
        logic       ready_line;
    } t_cpd_op;

    typedef struct packed {
        logic [7:0] code;
        logic       enable;
    } t_cpd_cfg;

endpackage

### src/command_packet_deframer.sv
// A single-result transaction passes through the operation queue and the output register.
// An accepted frame's parameters are read one by one from the parameter store, each
// result paced by the registered read (ST_RUN_RD) before its output write (ST_RUN_WR).
// An accepted frame with parameters stalls input from its check byte to its last result.
// Otherwise one input transaction per cycle unless the two-entry operation queue is full.
// Reset is synchronous and active low; the parameter store is not cleared.
// ============================================================================
// Command packet deframer
// Parses command, length, parameter and check bytes into result transactions.
// ============================================================================
module command_packet_deframer #(
    parameter int PARAM_DEPTH = cpd_pkg::PARAM_DEPTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  cpd_pkg::t_cpd_in   i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output cpd_pkg::t_cpd_out  o_out_data,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    import cpd_pkg::*;

    localparam int AW = $clog2(PARAM_DEPTH);

    t_cpd_cfg        r_cfg;
    t_cpd_op         push_op;
    t_cpd_op         head_op;
    logic            push;
    logic            pop;
    logic            q_empty;
    logic            q_full;
    logic            run_done;
    logic            wr_en;
    logic [AW-1:0]   wr_addr;
    logic [7:0]      wr_data;
    logic            rd_en;
    logic [AW-1:0]   rd_addr;
    logic [7:0]      rd_data;
    logic            cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (cfg_wr) begin
            case (paddr[2])
                REG_READY_ENABLE: r_cfg.enable <= pwdata[0];
                REG_READY_CODE:   r_cfg.code   <= pwdata[7:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_READY_ENABLE: prdata = {31'd0, r_cfg.enable};
            REG_READY_CODE:   prdata = {24'd0, r_cfg.code};
            default:          prdata = '0;
        endcase
    end

    cpd_front #(
        .PARAM_DEPTH(PARAM_DEPTH)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .i_cfg      (r_cfg),
        .o_push     (push),
        .o_push_op  (push_op),
        .i_q_full   (q_full),
        .i_run_done (run_done),
        .o_wr_en    (wr_en),
        .o_wr_addr  (wr_addr),
        .o_wr_data  (wr_data)
    );

    cpd_fifo u_fifo (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (push),
        .i_push_op (push_op),
        .i_pop     (pop),
        .o_head_op (head_op),
        .o_empty   (q_empty),
        .o_full    (q_full)
    );

    cpd_ram #(
        .WIDTH(8),
        .DEPTH(PARAM_DEPTH)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    cpd_back #(
        .PARAM_DEPTH(PARAM_DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head_op   (head_op),
        .i_q_empty   (q_empty),
        .o_pop       (pop),
        .o_rd_en     (rd_en),
        .o_rd_addr   (rd_addr),
        .i_rd_data   (rd_data),
        .o_run_done  (run_done),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule

### src/cpd_ram.sv
// ============================================================================
// Generic single-port-write RAM
// One write port and one read port with a registered read.
// ============================================================================
module cpd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

### src/cpd_fifo.sv
// ============================================================================
// Deframer operation queue
// Two-entry queue of decoded operations between the parser and the emitter.
// ============================================================================
module cpd_fifo (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  cpd_pkg::t_cpd_op  i_push_op,
    input  logic              i_pop,
    output cpd_pkg::t_cpd_op  o_head_op,
    output logic              o_empty,
    output logic              o_full
);
    import cpd_pkg::*;

    localparam int QDEPTH = 2;
    localparam int QAW    = $clog2(QDEPTH);

    t_cpd_op          r_mem [QDEPTH];
    logic [QAW-1:0]   r_wp;
    logic [QAW-1:0]   r_rp;
    logic [QAW:0]     r_count;
    logic [QAW-1:0]   n_wp;
    logic [QAW-1:0]   n_rp;
    logic [QAW:0]     n_count;

    always_comb begin
        n_wp    = r_wp;
        n_rp    = r_rp;
        n_count = r_count;
        if (i_push) begin
            n_wp = QAW'(r_wp + 1'b1);
        end
        if (i_pop) begin
            n_rp = QAW'(r_rp + 1'b1);
        end
        if (i_push && !i_pop) begin
            n_count = (QAW+1)'(r_count + 1'b1);
        end else if (!i_push && i_pop) begin
            n_count = (QAW+1)'(r_count - 1'b1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            r_wp    <= n_wp;
            r_rp    <= n_rp;
            r_count <= n_count;
        end
        if (i_push) begin
            r_mem[r_wp] <= i_push_op;
        end
    end

    assign o_head_op = r_mem[r_rp];
    assign o_empty   = (r_count == '0);
    assign o_full    = (r_count == (QAW+1)'(QDEPTH));

endmodule

### src/cpd_front.sv
// ============================================================================
// Deframer parser
// Accepts input transactions, tracks the frame and checksum, stores
// parameters and queues the resulting operations.
// ============================================================================
module cpd_front #(
    parameter int PARAM_DEPTH = cpd_pkg::PARAM_DEPTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  cpd_pkg::t_cpd_in               i_in_data,
    input  cpd_pkg::t_cpd_cfg              i_cfg,
    output logic                           o_push,
    output cpd_pkg::t_cpd_op               o_push_op,
    input  logic                           i_q_full,
    input  logic                           i_run_done,
    output logic                           o_wr_en,
    output logic [$clog2(PARAM_DEPTH)-1:0] o_wr_addr,
    output logic [7:0]                     o_wr_data
);
    import cpd_pkg::*;

    localparam int AW = $clog2(PARAM_DEPTH);
    localparam int FW = AW + 1;

    typedef enum logic [1:0] {
        PH_CMD,
        PH_LEN,
        PH_PARAM,
        PH_CHECK
    } t_phase;

    t_phase         r_phase;
    t_phase         n_phase;
    logic [7:0]     r_cmd;
    logic [7:0]     n_cmd;
    logic [7:0]     r_len;
    logic [7:0]     n_len;
    logic [FW-1:0]  r_fill;
    logic [FW-1:0]  n_fill;
    logic [FW-1:0]  fill_inc;
    logic [7:0]     r_xor;
    logic [7:0]     n_xor;
    logic [7:0]     r_acc;
    logic [7:0]     n_acc;
    logic           r_ready;
    logic           n_ready;
    logic           r_run_busy;
    logic           n_run_busy;
    logic           accept;
    logic [7:0]     b;

    assign o_in_stall = r_run_busy || i_q_full;
    assign accept     = i_in_valid && !o_in_stall;
    assign b          = i_in_data.byte_value;
    assign fill_inc   = FW'(r_fill + 1'b1);
    assign o_wr_addr  = AW'(r_fill);
    assign o_wr_data  = b;

    always_comb begin
        n_phase    = r_phase;
        n_cmd      = r_cmd;
        n_len      = r_len;
        n_fill     = r_fill;
        n_xor      = r_xor;
        n_acc      = r_acc;
        n_ready    = r_ready;
        n_run_busy = r_run_busy;
        o_push     = 1'b0;
        o_wr_en    = 1'b0;
        o_push_op  = '0;
        if (i_run_done) begin
            n_run_busy = 1'b0;
        end
        if (accept) begin
            case (i_in_data.kind)
                KIND_BYTE: begin
                    case (r_phase)
                        PH_CMD: begin
                            n_cmd   = b;
                            n_xor   = b;
                            n_phase = PH_LEN;
                        end
                        PH_LEN: begin
                            n_len   = b;
                            n_xor   = r_xor ^ b;
                            n_fill  = '0;
                            n_phase = (b == 8'd0) ? PH_CHECK : PH_PARAM;
                        end
                        PH_PARAM: begin
                            o_wr_en = 1'b1;
                            n_xor   = r_xor ^ b;
                            n_fill  = fill_inc;
                            if (fill_inc >= FW'(PARAM_DEPTH)) begin
                                n_phase             = PH_CMD;
                                o_push              = 1'b1;
                                o_push_op.event_res = EV_OVERFLOW;
                            end else if (8'(fill_inc) >= r_len) begin
                                n_phase = PH_CHECK;
                            end
                        end
                        default: begin
                            n_phase = PH_CMD;
                            o_push  = 1'b1;
                            if (b[5:0] != r_xor[5:0]) begin
                                o_push_op.event_res = EV_BAD_CHECK;
                            end else begin
                                if (i_cfg.enable && (i_cfg.code == r_cmd)) begin
                                    n_ready = 1'b0;
                                end
                                n_acc                 = r_xor;
                                o_push_op.event_res   = EV_PARAM;
                                o_push_op.command     = r_cmd;
                                o_push_op.param_count = r_len[4:0];
                                if (r_len != 8'd0) begin
                                    o_push_op.is_run  = 1'b1;
                                    o_push_op.run_len = (r_len > 8'(MAX_RUN)) ?
                                                        5'(MAX_RUN) : r_len[4:0];
                                    n_run_busy        = 1'b1;
                                end
                            end
                        end
                    endcase
                end
                KIND_END: begin
                    if (r_phase != PH_CMD) begin
                        n_phase             = PH_CMD;
                        o_push              = 1'b1;
                        o_push_op.event_res = EV_INCOMPLETE;
                    end
                end
                KIND_RAISE: begin
                    if (i_cfg.enable) begin
                        n_ready = 1'b1;
                    end
                    o_push              = 1'b1;
                    o_push_op.event_res = EV_RAISED;
                end
                default: begin
                end
            endcase
        end
        o_push_op.good_check = n_acc;
        o_push_op.ready_line = n_ready;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_CMD;
            r_cmd      <= '0;
            r_len      <= '0;
            r_fill     <= '0;
            r_xor      <= 8'hff;
            r_acc      <= 8'hff;
            r_ready    <= 1'b0;
            r_run_busy <= 1'b0;
        end else begin
            r_phase    <= n_phase;
            r_cmd      <= n_cmd;
            r_len      <= n_len;
            r_fill     <= n_fill;
            r_xor      <= n_xor;
            r_acc      <= n_acc;
            r_ready    <= n_ready;
            r_run_busy <= n_run_busy;
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_wr_en |-> !r_run_busy)
        else $error("parameter store written while a run is emitted");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_PARAM) |-> (r_fill < FW'(PARAM_DEPTH)))
        else $error("fill position beyond the parameter store");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |-> !i_q_full)
        else $error("operation pushed into a full queue");

endmodule

### src/cpd_back.sv
// ============================================================================
// Deframer emitter
// Takes queued operations and produces result transactions, reading the
// stored parameters of an accepted frame one by one.
// ============================================================================
module cpd_back #(
    parameter int PARAM_DEPTH = cpd_pkg::PARAM_DEPTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  cpd_pkg::t_cpd_op               i_head_op,
    input  logic                           i_q_empty,
    output logic                           o_pop,
    output logic                           o_rd_en,
    output logic [$clog2(PARAM_DEPTH)-1:0] o_rd_addr,
    input  logic [7:0]                     i_rd_data,
    output logic                           o_run_done,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output cpd_pkg::t_cpd_out              o_out_data
);
    import cpd_pkg::*;

    localparam int AW = $clog2(PARAM_DEPTH);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN_RD,
        ST_RUN_WR
    } t_state;

    t_state     r_state;
    t_state     n_state;
    t_cpd_op    r_op;
    t_cpd_op    n_op;
    logic [4:0] r_idx;
    logic [4:0] n_idx;
    logic       r_out_valid;
    logic       n_out_valid;
    t_cpd_out   r_out;
    t_cpd_out   n_out;
    logic       r_run_done;
    logic       n_run_done;
    logic       slot_free;
    logic       run_last;

    assign slot_free = !r_out_valid || !i_out_stall;
    assign run_last  = (r_idx == 5'(r_op.run_len - 5'd1));
    assign o_rd_en   = (r_state == ST_RUN_RD);
    assign o_rd_addr = AW'(r_idx);

    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        n_idx       = r_idx;
        n_out       = r_out;
        n_run_done  = 1'b0;
        n_out_valid = r_out_valid && i_out_stall;
        o_pop       = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (!i_q_empty) begin
                    if (i_head_op.is_run) begin
                        o_pop   = 1'b1;
                        n_op    = i_head_op;
                        n_idx   = '0;
                        n_state = ST_RUN_RD;
                    end else if (slot_free) begin
                        o_pop             = 1'b1;
                        n_out_valid       = 1'b1;
                        n_out.event_res   = i_head_op.event_res;
                        n_out.command     = i_head_op.command;
                        n_out.param_count = i_head_op.param_count;
                        n_out.param_index = '0;
                        n_out.param_byte  = '0;
                        n_out.last        = 1'b1;
                        n_out.good_check  = i_head_op.good_check;
                        n_out.ready_line  = i_head_op.ready_line;
                    end
                end
            end
            ST_RUN_RD: begin
                n_state = ST_RUN_WR;
            end
            ST_RUN_WR: begin
                if (slot_free) begin
                    n_out_valid       = 1'b1;
                    n_out.event_res   = EV_PARAM;
                    n_out.command     = r_op.command;
                    n_out.param_count = r_op.param_count;
                    n_out.param_index = r_idx;
                    n_out.param_byte  = i_rd_data;
                    n_out.last        = run_last;
                    n_out.good_check  = r_op.good_check;
                    n_out.ready_line  = r_op.ready_line;
                    if (run_last) begin
                        n_state    = ST_IDLE;
                        n_run_done = 1'b1;
                    end else begin
                        n_idx   = 5'(r_idx + 5'd1);
                        n_state = ST_RUN_RD;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_run_done  <= 1'b0;
            r_idx       <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_run_done  <= n_run_done;
            r_idx       <= n_idx;
        end
        r_op  <= n_op;
        r_out <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign o_run_done  = r_run_done;

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |-> (r_op.run_len != 5'd0))
        else $error("run started with zero length");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_run_done |-> ($past(r_state) == ST_RUN_WR) && (r_state == ST_IDLE))
        else $error("run completion without a final parameter");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RUN_WR) |-> (r_idx < r_op.run_len))
        else $error("parameter index beyond the run length");

endmodule
